@@ hdl/srtf_preemptive_scheduler_top_defines.svh @@
// ----------------------------------------------------------------------------
// SRTF scheduler assertion macros
// Shared concurrent assertion forms for the scheduler modules.
// ----------------------------------------------------------------------------
`ifndef SRTF_PREEMPTIVE_SCHEDULER_TOP_DEFINES_SVH
`define SRTF_PREEMPTIVE_SCHEDULER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, disabled during reset.
`define SRTF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, disabled during reset.
`define SRTF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/srtf_pkg.sv @@
// ----------------------------------------------------------------------------
// SRTF scheduler package
// Sizes, operation codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package srtf_pkg;

    localparam int SLOTS      = 8;
    localparam int TIME_BITS  = 16;
    localparam int SLOT_BITS  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int WORD_BITS  = 4 * TIME_BITS;

    localparam int OP_BITS    = 2;
    localparam int SLOTF_BITS = 3;
    localparam int FIELD_BITS = 16;

    localparam logic [OP_BITS-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_BITS-1:0] OP_TICK  = 2'd1;
    localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd2;

    typedef struct packed {
        logic                 load;
        logic                 clear;
        logic                 start;
        logic                 scan_rd;
        logic [SLOT_BITS-1:0] scan_idx;
        logic                 upd;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

@@ hdl/srtf_preemptive_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// SRTF preemptive scheduler, top level
// A load or clear word is applied as it is taken. A tick word is followed by
// a scan of the slot store, one slot per cycle through its single read port,
// then a drain, a select and an update step; no new word is taken until the
// update has written the result word, which waits for the output to be free.
// Synchronous active-low reset empties the table and zeroes time; slot
// store contents stay undefined until a slot is loaded.
// ----------------------------------------------------------------------------
module srtf_preemptive_scheduler_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [2:0] slot, [18:3] arrival, [34:19] burst, [39:35] zero.
    input  logic [39:0] i_s_tdata,
    // [1:0] operation.
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [2:0] running_slot, [3] finished, [19:4] finish_time,
    // [35:20] waiting_time, [51:36] first_wait, [52] all_done, [55:53] zero.
    output logic [55:0] o_m_tdata,
    // [0] idle.
    output logic        o_m_tuser
);

    srtf_pkg::t_cmd    w_cmd;
    srtf_pkg::t_status w_status;

    logic                                w_idle;
    logic [srtf_pkg::SLOTF_BITS-1:0]     w_slot;
    logic                                w_finished;
    logic [srtf_pkg::FIELD_BITS-1:0]     w_ftime;
    logic [srtf_pkg::FIELD_BITS-1:0]     w_wait;
    logic [srtf_pkg::FIELD_BITS-1:0]     w_fwait;
    logic                                w_all_done;

    srtf_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .i_op      (i_s_tuser),
        .i_status  (w_status),
        .o_s_tready(o_s_tready),
        .o_cmd     (w_cmd)
    );

    srtf_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_slot        (i_s_tdata[2:0]),
        .i_arrival     (i_s_tdata[18:3]),
        .i_burst       (i_s_tdata[34:19]),
        .i_m_tready    (i_m_tready),
        .o_status      (w_status),
        .o_m_tvalid    (o_m_tvalid),
        .o_idle        (w_idle),
        .o_running_slot(w_slot),
        .o_finished    (w_finished),
        .o_finish_time (w_ftime),
        .o_waiting_time(w_wait),
        .o_first_wait  (w_fwait),
        .o_all_done    (w_all_done)
    );

    assign o_m_tdata = {3'b000, w_all_done, w_fwait, w_wait, w_ftime, w_finished, w_slot};
    assign o_m_tuser = w_idle;

endmodule

@@ hdl/srtf_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module srtf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/srtf_ctrl.sv @@
// ----------------------------------------------------------------------------
// SRTF scheduler controller
// Sequences the slot scan, the pick readback and the result update.
// ----------------------------------------------------------------------------
`include "srtf_preemptive_scheduler_top_defines.svh"

module srtf_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic [srtf_pkg::OP_BITS-1:0]  i_op,
    input  srtf_pkg::t_status             i_status,
    output logic                          o_s_tready,
    output srtf_pkg::t_cmd                o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_SEL,
        S_UPD
    } t_state;

    t_state                          r_state;
    t_state                          n_state;
    logic [srtf_pkg::SLOT_BITS-1:0]  r_cnt;
    logic [srtf_pkg::SLOT_BITS-1:0]  n_cnt;
    logic                            w_accept;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = w_accept && (i_op == srtf_pkg::OP_LOAD);
        o_cmd.clear    = w_accept && (i_op == srtf_pkg::OP_CLEAR);
        o_cmd.start    = w_accept && (i_op == srtf_pkg::OP_TICK);
        o_cmd.scan_rd  = (r_state == S_SCAN);
        o_cmd.scan_idx = r_cnt;
        o_cmd.upd      = (r_state == S_UPD) && i_status.out_free;
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.start) begin
                    n_state = S_SCAN;
                    n_cnt   = '0;
                end
            end
            S_SCAN: begin
                if (r_cnt == srtf_pkg::SLOT_BITS'(srtf_pkg::SLOTS - 1)) begin
                    n_state = S_DRAIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_SEL;
            end
            S_SEL: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    `SRTF_ASSERT_NEXT(a_tick_starts_scan, o_cmd.start, (r_state == S_SCAN) && (r_cnt == '0), "tick did not start a scan at slot zero")
    `SRTF_ASSERT_NOW(a_no_accept_busy, (r_state != S_IDLE), !o_cmd.load && !o_cmd.clear && !o_cmd.start, "word taken while a tick is in progress")

endmodule

@@ hdl/srtf_datapath.sv @@
// ----------------------------------------------------------------------------
// SRTF scheduler datapath
// Slot store, slot flags, time counter, minimum search and result register.
// ----------------------------------------------------------------------------
`include "srtf_preemptive_scheduler_top_defines.svh"

module srtf_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  srtf_pkg::t_cmd                      i_cmd,
    input  logic [srtf_pkg::SLOTF_BITS-1:0]     i_slot,
    input  logic [srtf_pkg::FIELD_BITS-1:0]     i_arrival,
    input  logic [srtf_pkg::FIELD_BITS-1:0]     i_burst,
    input  logic                                i_m_tready,
    output srtf_pkg::t_status                   o_status,
    output logic                                o_m_tvalid,
    output logic                                o_idle,
    output logic [srtf_pkg::SLOTF_BITS-1:0]     o_running_slot,
    output logic                                o_finished,
    output logic [srtf_pkg::FIELD_BITS-1:0]     o_finish_time,
    output logic [srtf_pkg::FIELD_BITS-1:0]     o_waiting_time,
    output logic [srtf_pkg::FIELD_BITS-1:0]     o_first_wait,
    output logic                                o_all_done
);

    localparam int T  = srtf_pkg::TIME_BITS;
    localparam int SB = srtf_pkg::SLOT_BITS;
    localparam int N  = srtf_pkg::SLOTS;
    localparam int FB = srtf_pkg::FIELD_BITS;

    logic [N-1:0]                    r_valid;
    logic [N-1:0]                    r_done;
    logic [N-1:0]                    r_started;
    logic [T-1:0]                    r_time;
    logic                            r_cmp_vld;
    logic [SB-1:0]                   r_cmp_idx;
    logic                            r_have;
    logic [SB-1:0]                   r_pick;
    logic [T-1:0]                    r_best;

    logic                            r_out_valid;
    logic                            r_out_idle;
    logic [srtf_pkg::SLOTF_BITS-1:0] r_out_slot;
    logic                            r_out_finished;
    logic [FB-1:0]                   r_out_ftime;
    logic [FB-1:0]                   r_out_wait;
    logic [FB-1:0]                   r_out_fwait;
    logic                            r_out_all_done;

    logic                            w_load_ok;
    logic [SB-1:0]                   w_load_idx;
    logic                            w_we;
    logic [SB-1:0]                   w_waddr;
    logic [srtf_pkg::WORD_BITS-1:0]  w_wdata;
    logic [SB-1:0]                   w_raddr;
    logic [srtf_pkg::WORD_BITS-1:0]  w_rdata;

    logic [T-1:0]                    w_arr;
    logic [T-1:0]                    w_rem;
    logic [T-1:0]                    w_burst;
    logic [T-1:0]                    w_fs;
    logic                            w_cand;
    logic [T-1:0]                    w_rem_new;
    logic [T-1:0]                    w_fs_new;
    logic [T-1:0]                    w_time_new;
    logic [T:0]                      w_used;
    logic [T:0]                      w_wait_full;
    logic [T-1:0]                    w_fwait_full;
    logic                            w_fin;
    logic [N-1:0]                    w_pick_hot;
    logic [N-1:0]                    w_done_next;
    logic                            w_all_done;
    logic [T-1:0]                    w_load_burst;

    assign w_load_ok    = (32'(i_slot) < 32'(N));
    assign w_load_idx   = SB'(i_slot);
    assign w_load_burst = T'(i_burst);

    assign w_arr   = w_rdata[T-1:0];
    assign w_rem   = w_rdata[2*T-1:T];
    assign w_burst = w_rdata[3*T-1:2*T];
    assign w_fs    = w_rdata[4*T-1:3*T];

    assign w_cand = r_cmp_vld && r_valid[r_cmp_idx] && !r_done[r_cmp_idx]
                    && (w_arr <= r_time);

    assign w_rem_new    = w_rem - 1'b1;
    assign w_fs_new     = r_started[r_pick] ? w_fs : r_time;
    assign w_time_new   = (r_time == {T{1'b1}}) ? r_time : r_time + 1'b1;
    assign w_used       = {1'b0, w_arr} + {1'b0, w_burst};
    assign w_wait_full  = ({1'b0, w_time_new} > w_used) ? ({1'b0, w_time_new} - w_used) : '0;
    assign w_fwait_full = w_fs_new - w_arr;
    assign w_fin        = r_have && (w_rem_new == '0);
    assign w_pick_hot   = N'(1) << r_pick;
    assign w_done_next  = r_done | (w_fin ? w_pick_hot : '0);
    assign w_all_done   = &(~r_valid | w_done_next);

    assign w_we    = (i_cmd.load && w_load_ok) || (i_cmd.upd && r_have);
    assign w_waddr = i_cmd.load ? w_load_idx : r_pick;
    assign w_wdata = i_cmd.load ? {{T{1'b0}}, w_load_burst, w_load_burst, T'(i_arrival)}
                                : {w_fs_new, w_burst, w_rem_new, w_arr};
    assign w_raddr = i_cmd.scan_rd ? i_cmd.scan_idx : r_pick;

    srtf_ram #(
        .WIDTH(srtf_pkg::WORD_BITS),
        .DEPTH(N)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_done      <= '0;
            r_started   <= '0;
            r_time      <= '0;
            r_cmp_vld   <= 1'b0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan_rd;
            if (i_cmd.clear) begin
                r_valid   <= '0;
                r_done    <= '0;
                r_started <= '0;
                r_time    <= '0;
            end else if (i_cmd.load && w_load_ok) begin
                r_valid[w_load_idx]   <= 1'b1;
                r_started[w_load_idx] <= 1'b0;
                r_done[w_load_idx]    <= (w_load_burst == '0);
            end else if (i_cmd.upd) begin
                r_time <= w_time_new;
                r_done <= w_done_next;
                if (r_have) begin
                    r_started[r_pick] <= 1'b1;
                end
            end
            if (i_cmd.start) begin
                r_have <= 1'b0;
            end else if (w_cand && (!r_have || (w_rem < r_best))) begin
                r_have <= 1'b1;
            end
            if (i_cmd.upd) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= i_cmd.scan_idx;
        if (i_cmd.start) begin
            r_pick <= '0;
        end else if (w_cand && (!r_have || (w_rem < r_best))) begin
            r_pick <= r_cmp_idx;
            r_best <= w_rem;
        end
        if (i_cmd.upd) begin
            r_out_idle     <= !r_have;
            r_out_slot     <= r_have ? srtf_pkg::SLOTF_BITS'(r_pick) : '0;
            r_out_finished <= w_fin;
            r_out_ftime    <= FB'(w_time_new);
            r_out_wait     <= w_fin ? FB'(w_wait_full) : '0;
            r_out_fwait    <= w_fin ? FB'(w_fwait_full) : '0;
            r_out_all_done <= w_all_done;
        end
    end

    assign o_status.out_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid        = r_out_valid;
    assign o_idle            = r_out_idle;
    assign o_running_slot    = r_out_slot;
    assign o_finished        = r_out_finished;
    assign o_finish_time     = r_out_ftime;
    assign o_waiting_time    = r_out_wait;
    assign o_first_wait      = r_out_fwait;
    assign o_all_done        = r_out_all_done;

    `SRTF_ASSERT_NOW(a_upd_needs_room, i_cmd.upd, !r_out_valid || i_m_tready, "result update while the output word is still held")
    `SRTF_ASSERT_NOW(a_pick_is_live, i_cmd.upd && r_have, r_valid[r_pick] && !r_done[r_pick], "picked slot is not a live job")
    `SRTF_ASSERT_NEXT(a_result_flags, i_cmd.upd && !r_have, r_out_valid && r_out_idle && !r_out_finished, "idle tick reported a finished job")

endmodule

@@ tb/tb_srtf_preemptive_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// SRTF preemptive scheduler testbench
// Drives load, tick, clear and unused words into the scheduler. An
// in-bench model of the slot table predicts each tick report, or a directed
// word carries its own, and each report is checked against it field by
// field. A short table of directed words comes first. Random job mixes with
// idle bursts on both sides follow.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_srtf_preemptive_scheduler_top;

    localparam int OP_BITS   = srtf_pkg::OP_BITS;
    localparam int TIME_BITS = srtf_pkg::TIME_BITS;
    localparam int SLOTS     = srtf_pkg::SLOTS;

    localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    typedef struct packed {
        logic                  idle;
        logic [2:0]            running_slot;
        logic                  finished;
        logic [TIME_BITS-1:0]  finish_time;
        logic [TIME_BITS-1:0]  waiting_time;
        logic [TIME_BITS-1:0]  first_wait;
        logic                  all_done;
    } t_tick_report;

    typedef struct {
        logic [OP_BITS-1:0]    op;
        logic [2:0]            slot;
        logic [TIME_BITS-1:0]  arrival;
        logic [TIME_BITS-1:0]  burst;
        bit                    typed;
        t_tick_report          report;
    } t_sched_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [39:0] i_s_tdata;
    logic [1:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [55:0] o_m_tdata;
    logic        o_m_tuser;

    srtf_preemptive_scheduler_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    logic [TIME_BITS-1:0] sim_now;
    bit                   job_valid   [SLOTS];
    bit                   job_done    [SLOTS];
    bit                   job_started [SLOTS];
    logic [TIME_BITS-1:0] job_arrival [SLOTS];
    logic [TIME_BITS-1:0] job_left    [SLOTS];
    logic [TIME_BITS-1:0] job_burst   [SLOTS];
    logic [TIME_BITS-1:0] job_first   [SLOTS];

    t_tick_report  expected_reports [$];
    t_sched_word   directed_rows [$];
    bit            word_typed;
    t_tick_report  word_report;
    int            fail_count;
    int            rx_hold_left;
    bit            hold_go;
    bit            quiet;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #60_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic t_sched_word mk(input logic [OP_BITS-1:0] op, input int slot,
                                       input int arrival, input int burst);
        t_sched_word w;
        w.op      = op;
        w.slot    = slot[2:0];
        w.arrival = arrival[TIME_BITS-1:0];
        w.burst   = burst[TIME_BITS-1:0];
        w.typed   = 1'b0;
        w.report  = '0;
        return w;
    endfunction

    function automatic t_tick_report mk_report(input bit idle, input int slot, input bit fin,
                                               input int ft, input int wt, input int fw,
                                               input bit all_done);
        t_tick_report r;
        r.idle         = idle;
        r.running_slot = slot[2:0];
        r.finished     = fin;
        r.finish_time  = ft[TIME_BITS-1:0];
        r.waiting_time = wt[TIME_BITS-1:0];
        r.first_wait   = fw[TIME_BITS-1:0];
        r.all_done     = all_done;
        return r;
    endfunction

    function automatic t_sched_word mk_typed(input logic [OP_BITS-1:0] op,
                                             input t_tick_report r);
        t_sched_word w;
        w        = mk(op, 0, 0, 0);
        w.typed  = 1'b1;
        w.report = r;
        return w;
    endfunction

    function automatic string show_report(input t_tick_report r);
        return $sformatf("idle=%0d slot=%0d fin=%0d ft=%0d wt=%0d fw=%0d done=%0d",
                         r.idle, r.running_slot, r.finished, r.finish_time,
                         r.waiting_time, r.first_wait, r.all_done);
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    task automatic clear_schedule();
        for (int i = 0; i < SLOTS; i++) begin
            job_valid[i]   = 1'b0;
            job_done[i]    = 1'b0;
            job_started[i] = 1'b0;
        end
        sim_now = '0;
    endtask

    task automatic schedule_predict(input logic [OP_BITS-1:0] op, input logic [2:0] slot,
                                    input logic [TIME_BITS-1:0] arrival,
                                    input logic [TIME_BITS-1:0] burst,
                                    output bit produced, output t_tick_report r);
        int             pick;
        logic [TIME_BITS-1:0] best;
        logic [TIME_BITS:0]   used;
        bit             all_done;
        produced = 1'b0;
        r        = '0;
        pick     = -1;
        best     = '0;
        if (op == srtf_pkg::OP_LOAD) begin
            job_valid[slot]   = 1'b1;
            job_started[slot] = 1'b0;
            job_done[slot]    = (burst == '0);
            job_arrival[slot] = arrival;
            job_burst[slot]   = burst;
            job_left[slot]    = burst;
            job_first[slot]   = '0;
        end else if (op == srtf_pkg::OP_CLEAR) begin
            clear_schedule();
        end else if (op == srtf_pkg::OP_TICK) begin
            produced = 1'b1;
            for (int i = 0; i < SLOTS; i++) begin
                if (job_valid[i] && !job_done[i] && job_arrival[i] <= sim_now) begin
                    if (pick < 0 || job_left[i] < best) begin
                        best = job_left[i];
                        pick = i;
                    end
                end
            end
            if (pick < 0) begin
                r.idle = 1'b1;
            end else begin
                if (!job_started[pick]) begin
                    job_started[pick] = 1'b1;
                    job_first[pick]   = sim_now;
                end
                job_left[pick] = job_left[pick] - 1'b1;
                r.running_slot = pick[2:0];
            end
            if (sim_now != TIME_MAX) begin
                sim_now = sim_now + 1'b1;
            end
            if (pick >= 0) begin
                if (job_left[pick] == '0) begin
                    used = {1'b0, job_arrival[pick]} + {1'b0, job_burst[pick]};
                    job_done[pick] = 1'b1;
                    r.finished     = 1'b1;
                    r.waiting_time = ({1'b0, sim_now} > used) ? (sim_now - used[TIME_BITS-1:0])
                                                              : '0;
                    r.first_wait   = job_first[pick] - job_arrival[pick];
                end
            end
            r.finish_time = sim_now;
            all_done = 1'b1;
            for (int i = 0; i < SLOTS; i++) begin
                if (job_valid[i] && !job_done[i]) begin
                    all_done = 1'b0;
                end
            end
            r.all_done = all_done;
        end
    endtask

    always @(posedge i_clk) begin
        bit           produced;
        t_tick_report predicted;
        t_tick_report got;
        t_tick_report want;
        if (!i_rst_n) begin
            clear_schedule();
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                schedule_predict(i_s_tuser, i_s_tdata[2:0], i_s_tdata[18:3],
                                 i_s_tdata[34:19], produced, predicted);
                if (produced) begin
                    expected_reports.push_back(word_typed ? word_report : predicted);
                end
            end
            if (o_m_tvalid && i_m_tready) begin
                got.idle         = o_m_tuser;
                got.running_slot = o_m_tdata[2:0];
                got.finished     = o_m_tdata[3];
                got.finish_time  = o_m_tdata[19:4];
                got.waiting_time = o_m_tdata[35:20];
                got.first_wait   = o_m_tdata[51:36];
                got.all_done     = o_m_tdata[52];
                if (expected_reports.size() == 0) begin
                    note_failure({"unexpected report: ", show_report(got)});
                end else begin
                    want = expected_reports.pop_front();
                    if (got.idle !== want.idle || got.running_slot !== want.running_slot ||
                        got.finished !== want.finished ||
                        got.finish_time !== want.finish_time ||
                        got.waiting_time !== want.waiting_time ||
                        got.first_wait !== want.first_wait ||
                        got.all_done !== want.all_done) begin
                        note_failure({"report mismatch: expected ", show_report(want),
                                      " got ", show_report(got)});
                    end
                end
            end
        end
    end

    initial begin
        int  rx_left;
        bit  rx_level;
        bit  hold_used;
        rx_left      = 0;
        rx_level     = 1'b1;
        hold_used    = 1'b0;
        rx_hold_left = 0;
        i_m_tready   = 1'b1;
        forever begin
            @(negedge i_clk);
            if (hold_go && !hold_used) begin
                hold_used    = 1'b1;
                rx_hold_left = 300;
            end
            if (rx_hold_left > 0) begin
                i_m_tready <= 1'b0;
                rx_hold_left--;
            end else if (quiet) begin
                i_m_tready <= 1'b1;
            end else begin
                if (rx_left == 0) begin
                    rx_level = ($urandom_range(0, 2) != 0);
                    rx_left  = $urandom_range(1, 15);
                end
                i_m_tready <= rx_level;
                rx_left--;
            end
        end
    end

    function automatic int pick_gap();
        if (quiet || rx_hold_left > 0) begin
            return 0;
        end
        return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
    endfunction

    task automatic drive_word(input t_sched_word w, input int gap);
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid  <= 1'b1;
        i_s_tdata   <= {5'd0, w.burst, w.arrival, w.slot};
        i_s_tuser   <= w.op;
        word_typed  <= w.typed;
        word_report <= w.report;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    function automatic t_sched_word random_word();
        t_sched_word w;
        int          pick;
        int          arr;
        w    = mk(srtf_pkg::OP_LOAD, int'($urandom), int'($urandom), int'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
            w.op = srtf_pkg::OP_CLEAR;
        end else if (pick < 5) begin
            w.op = OP_UNUSED;
        end else if (pick < 30) begin
            w.op = srtf_pkg::OP_LOAD;
            if ($urandom_range(0, 15) != 0) begin
                arr = int'(sim_now) + int'($urandom_range(0, 10))
                      - int'($urandom_range(0, 3));
                if (arr < 0) begin
                    arr = 0;
                end
                w.arrival = arr[TIME_BITS-1:0];
            end
            case ($urandom_range(0, 29))
                0: w.burst = '0;
                1, 2: w.burst = TIME_BITS'($urandom);
                default: w.burst = TIME_BITS'($urandom_range(1, 12));
            endcase
        end else begin
            w.op = srtf_pkg::OP_TICK;
        end
        return w;
    endfunction

    initial begin
        t_sched_word w;
        int          counted;
        int          waited;
        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_s_tuser    = srtf_pkg::OP_LOAD;
        word_typed   = 1'b0;
        word_report  = '0;
        fail_count   = 0;
        hold_go      = 1'b0;
        quiet        = 1'b0;

        directed_rows.push_back(mk_typed(srtf_pkg::OP_TICK, mk_report(1, 0, 0, 1, 0, 0, 1)));
        directed_rows.push_back(mk(OP_UNUSED, 7, 16'hFFFF, 16'hFFFF));
        directed_rows.push_back(mk(srtf_pkg::OP_LOAD, 0, 0, 0));
        directed_rows.push_back(mk_typed(srtf_pkg::OP_TICK, mk_report(1, 0, 0, 2, 0, 0, 1)));
        directed_rows.push_back(mk(srtf_pkg::OP_LOAD, 7, 16'hFFFF, 16'hFFFF));
        directed_rows.push_back(mk(srtf_pkg::OP_LOAD, 1, 0, 1));
        directed_rows.push_back(mk(srtf_pkg::OP_TICK, 0, 0, 0));
        directed_rows.push_back(mk(srtf_pkg::OP_LOAD, 2, 3, 3));
        directed_rows.push_back(mk(srtf_pkg::OP_LOAD, 3, 4, 1));
        directed_rows.push_back(mk(srtf_pkg::OP_TICK, 0, 0, 0));
        directed_rows.push_back(mk(srtf_pkg::OP_TICK, 7, 16'hFFFF, 16'hFFFF));
        directed_rows.push_back(mk(srtf_pkg::OP_TICK, 0, 0, 0));
        directed_rows.push_back(mk(srtf_pkg::OP_LOAD, 4, 0, 1));
        directed_rows.push_back(mk(srtf_pkg::OP_LOAD, 5, 0, 1));
        directed_rows.push_back(mk(srtf_pkg::OP_TICK, 0, 0, 0));
        directed_rows.push_back(mk(srtf_pkg::OP_TICK, 0, 0, 0));
        directed_rows.push_back(mk(srtf_pkg::OP_TICK, 0, 0, 0));
        directed_rows.push_back(mk(srtf_pkg::OP_LOAD, 2, 0, 2));
        directed_rows.push_back(mk(srtf_pkg::OP_TICK, 0, 0, 0));
        directed_rows.push_back(mk(srtf_pkg::OP_TICK, 0, 0, 0));
        directed_rows.push_back(mk(srtf_pkg::OP_CLEAR, 5, 16'h5555, 16'hAAAA));
        directed_rows.push_back(mk_typed(srtf_pkg::OP_TICK, mk_report(1, 0, 0, 1, 0, 0, 1)));
        directed_rows.push_back(mk(srtf_pkg::OP_LOAD, 6, 0, 16'hFFFF));
        directed_rows.push_back(mk_typed(srtf_pkg::OP_TICK, mk_report(0, 6, 0, 2, 0, 0, 0)));
        directed_rows.push_back(mk(srtf_pkg::OP_CLEAR, 2, 16'hAAAA, 16'h5555));

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            drive_word(directed_rows[i], pick_gap());
        end

        counted = 0;
        while (counted < 400) begin
            if (counted == 320) begin
                quiet = 1'b1;
            end
            if (counted == 100) begin
                hold_go = 1'b1;
            end
            if (counted == 200) begin
                @(negedge i_clk);
                i_s_tvalid <= 1'b0;
                while (expected_reports.size() != 0) @(posedge i_clk);
            end
            w = random_word();
            drive_word(w, pick_gap());
            if (w.op != OP_UNUSED) begin
                counted++;
            end
        end

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        waited = 0;
        while (expected_reports.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (24) @(posedge i_clk);
        if (expected_reports.size() != 0) begin
            note_failure($sformatf("%0d reports never arrived", expected_reports.size()));
        end
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
